// File: rtl/fba_pkg.sv
// ----------------------------------------------------------------------------
// fba_pkg: shared definitions for the frame bitmap allocator
// Field widths, request and status codes, register indexes and the
// command / status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package fba_pkg;

    // default for the top-level frame capacity parameter
    localparam int MAX_FRAMES_DEF = 32768;

    // frame geometry
    localparam int PAGE_SHIFT = 12;
    localparam int FRAME_W    = 16;
    localparam int WORD_BITS  = 32;
    localparam int WORD_SHIFT = 5;
    localparam int BIT_W      = 5;

    // payload widths
    localparam int ACTION_W    = 2;
    localparam int ADDR_W      = 32;
    localparam int END_W       = 33;
    localparam int STATUS_W    = 2;
    localparam int IN_DATA_W   = 72;
    localparam int OUT_DATA_W  = 32;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    // register reset values
    localparam logic [FRAME_W-1:0] FRAME_COUNT_RST   = 16'd4096;
    localparam logic [FRAME_W-1:0] FIRST_MANAGED_RST = 16'd256;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_COUNT   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_MANAGED = 8'd1;

    // request kinds
    localparam logic [ACTION_W-1:0] ACT_ALLOC      = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FREE       = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_MARK_USED  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_MARK_FREE  = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FREE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic clr_wr;    // write one all-used word of the reset sweep
        logic load;      // capture the incoming request
        logic decode;    // compute frame bounds and immediate status
        logic rd;        // read the bitmap word at the pointer
        logic chk;       // evaluate the word just read, write it back unless an allocate found no free frame
        logic inc;       // advance to the next bitmap word
        logic out_load;  // move the result into the output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic sweep_last;  // reset sweep is at the final word
        logic skip;        // request answers without touching the bitmap
        logic last_word;   // pointer is at the final word of the span
        logic alloc_hit;   // word just read holds a free frame in span
        logic is_alloc;    // current request is an allocate
        logic out_free;    // output register can take a result
    } stat_t;

endpackage

// File: rtl/fba_ram.sv
// ----------------------------------------------------------------------------
// fba_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/fba_ctrl.sv
// ----------------------------------------------------------------------------
// fba_ctrl: allocator sequencer
// Runs the reset sweep, then steps each request through decode, a
// read / check loop over bitmap words, and the result handoff.
// ----------------------------------------------------------------------------
module fba_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output fba_pkg::cmd_t  cmd,
    input  fba_pkg::stat_t stat
);
    import fba_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_DECODE = 6'b000100,
        S_READ   = 6'b001000,
        S_CHECK  = 6'b010000,
        S_RESP   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_accept;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_accept = in_valid && in_ready;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                state_next = stat.skip ? S_RESP : S_READ;
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.chk = 1'b1;
                if ((stat.is_alloc && stat.alloc_hit) || stat.last_word)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.inc    = 1'b1;
                    state_next = S_READ;
                end
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef ASSERT_OFF
    a_accept_then_decode: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == S_DECODE))
        else $error("accepted request did not enter decode");

    a_check_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |-> ($past(state_reg) == S_READ))
        else $error("word check without a preceding read");

    a_result_only_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> ($past(state_reg) == S_RESP || $past(state_reg) == S_DECODE
                          || $past(state_reg) == S_CHECK))
        else $error("result handed off without a request in flight");
`endif

endmodule

// File: rtl/fba_datapath.sv
// ----------------------------------------------------------------------------
// fba_datapath: allocator datapath
// Configuration registers, request decode, bitmap RAM, word pointer,
// span mask, lowest-free-bit pick and the result output register.
// ----------------------------------------------------------------------------
module fba_datapath #(
    parameter int MAX_FRAMES = fba_pkg::MAX_FRAMES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  fba_pkg::cmd_t                    cmd,
    output fba_pkg::stat_t                   stat,
    input  logic                             cfg_valid,
    input  logic [fba_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [fba_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [fba_pkg::ACTION_W-1:0]     in_action,
    input  logic [fba_pkg::ADDR_W-1:0]       in_address,
    input  logic [fba_pkg::END_W-1:0]        in_range_end,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic [fba_pkg::STATUS_W-1:0]     out_status,
    output logic [fba_pkg::ADDR_W-1:0]       out_frame_address
);
    import fba_pkg::*;

    localparam int WORD_COUNT = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

    // configuration
    logic [FRAME_W-1:0]  cfg_count_reg;
    logic [FRAME_W-1:0]  cfg_first_reg;

    // captured request
    logic [ACTION_W-1:0] req_action_reg;
    logic [ADDR_W-1:0]   req_addr_reg;
    logic [END_W-1:0]    req_end_reg;

    // decoded span and work state
    logic [FRAME_W-1:0]  first_reg;
    logic [FRAME_W-1:0]  last_reg;
    logic                alloc_reg;
    logic                set_reg;
    logic [WIDX-1:0]     ptr_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [ADDR_W-1:0]   res_addr_reg;

    // output register
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [ADDR_W-1:0]   out_addr_reg;

    // decode signals
    logic [FRAME_W-1:0]  live_n;
    logic [END_W-1:0]    top_b;
    logic [END_W-1:0]    base_b;
    logic [END_W-1:0]    start_b;
    logic [END_W-1:0]    end_clamp;
    logic [END_W-1:0]    end_m1;
    logic [FRAME_W-1:0]  start_frame;
    logic [FRAME_W-1:0]  end_frame;
    logic [FRAME_W-1:0]  dec_first;
    logic [FRAME_W-1:0]  dec_last;
    logic                dec_skip;
    logic [STATUS_W-1:0] dec_status;

    // word signals
    logic [WIDX-1:0]      first_word_idx;
    logic [WIDX-1:0]      last_word_idx;
    logic [BIT_W-1:0]     lo_bit;
    logic [BIT_W-1:0]     hi_bit;
    logic [WORD_BITS-1:0] bit_mask;
    logic [WORD_BITS-1:0] rd_data;
    logic [WORD_BITS-1:0] free_vec;
    logic [WORD_BITS-1:0] pick;
    logic [BIT_W-1:0]     pick_idx;
    logic                 alloc_hit;
    logic [ADDR_W-1:0]    alloc_addr;
    logic                 wr_en;
    logic [WORD_BITS-1:0] wr_data;
    logic                 out_free;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_count_reg <= FRAME_COUNT_RST;
            cfg_first_reg <= FIRST_MANAGED_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FRAME_COUNT:   cfg_count_reg <= cfg_data;
                CFG_FIRST_MANAGED: cfg_first_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_action_reg <= in_action;
            req_addr_reg   <= in_address;
            req_end_reg    <= in_range_end;
        end
    end

    // effective frame count and byte bounds
    always_comb
    begin
        if (32'(cfg_count_reg) > 32'(MAX_FRAMES))
        begin
            live_n = FRAME_W'(MAX_FRAMES);
        end
        else
        begin
            live_n = cfg_count_reg;
        end
    end

    assign top_b       = END_W'(live_n) << PAGE_SHIFT;
    assign base_b      = END_W'(cfg_first_reg) << PAGE_SHIFT;
    assign start_b     = END_W'(req_addr_reg);
    assign end_clamp   = (req_end_reg > top_b) ? top_b : req_end_reg;
    assign end_m1      = end_clamp - END_W'(1);
    assign start_frame = req_addr_reg[PAGE_SHIFT +: FRAME_W];
    assign end_frame   = end_m1[PAGE_SHIFT +: FRAME_W];

    // request decode: frame span and early answer
    always_comb
    begin
        dec_first  = start_frame;
        dec_last   = end_frame;
        dec_skip   = 1'b0;
        dec_status = ST_IGNORED;
        case (req_action_reg)
            ACT_ALLOC:
            begin
                dec_first  = cfg_first_reg;
                dec_last   = live_n - FRAME_W'(1);
                dec_skip   = (cfg_first_reg >= live_n);
                dec_status = ST_NO_FREE;
            end
            ACT_FREE:
            begin
                dec_last = start_frame;
                dec_skip = (start_b < base_b) || (start_b >= top_b);
            end
            // both range marks
            default:
            begin
                dec_skip = (req_end_reg <= start_b) || (start_b >= top_b);
            end
        endcase
    end

    // span mask for the word at the pointer
    assign first_word_idx = WIDX'(first_reg >> WORD_SHIFT);
    assign last_word_idx  = WIDX'(last_reg >> WORD_SHIFT);
    assign lo_bit   = (ptr_reg == first_word_idx) ? first_reg[BIT_W-1:0] : '0;
    assign hi_bit   = (ptr_reg == last_word_idx) ? last_reg[BIT_W-1:0] : '1;
    assign bit_mask = ({WORD_BITS{1'b1}} << lo_bit)
                    & ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - hi_bit));

    // lowest free frame inside the span
    assign free_vec  = ~rd_data & bit_mask;
    assign pick      = free_vec & (~free_vec + WORD_BITS'(1));
    assign alloc_hit = |free_vec;

    always_comb
    begin
        pick_idx = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (pick[i])
            begin
                pick_idx = pick_idx | BIT_W'(i);
            end
        end
    end

    assign alloc_addr = ADDR_W'({ptr_reg, pick_idx}) << PAGE_SHIFT;

    // bitmap write-back data
    always_comb
    begin
        if (cmd.clr_wr)
        begin
            wr_data = '1;
        end
        else if (alloc_reg)
        begin
            wr_data = rd_data | pick;
        end
        else if (set_reg)
        begin
            wr_data = rd_data | bit_mask;
        end
        else
        begin
            wr_data = rd_data & ~bit_mask;
        end
    end

    assign wr_en = cmd.clr_wr || (cmd.chk && (!alloc_reg || alloc_hit));

    // bitmap storage
    fba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_COUNT),
        .AW    (WIDX)
    ) u_bitmap (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (ptr_reg),
        .wr_data (wr_data),
        .rd_en   (cmd.rd),
        .rd_addr (ptr_reg),
        .rd_data (rd_data)
    );

    // word pointer, shared by the reset sweep and the request walk
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
        end
        else if (cmd.decode)
        begin
            ptr_reg <= WIDX'(dec_first >> WORD_SHIFT);
        end
        else if (cmd.clr_wr || cmd.inc)
        begin
            ptr_reg <= ptr_reg + WIDX'(1);
        end
    end

    // span and pending result
    always_ff @(posedge clk)
    begin
        if (cmd.decode)
        begin
            first_reg      <= dec_first;
            last_reg       <= dec_last;
            alloc_reg      <= (req_action_reg == ACT_ALLOC);
            set_reg        <= (req_action_reg == ACT_MARK_USED);
            res_status_reg <= dec_status;
            res_addr_reg   <= '0;
        end
        else if (cmd.chk)
        begin
            if (alloc_reg && alloc_hit)
            begin
                res_status_reg <= ST_DONE;
                res_addr_reg   <= alloc_addr;
            end
            else if (alloc_reg)
            begin
                res_status_reg <= ST_NO_FREE;
                res_addr_reg   <= '0;
            end
            else
            begin
                res_status_reg <= ST_DONE;
                res_addr_reg   <= '0;
            end
        end
    end

    // result output register
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_addr_reg   <= res_addr_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_status        = out_status_reg;
    assign out_frame_address = out_addr_reg;

    // status to the controller
    assign stat.sweep_last = (ptr_reg == WIDX'(WORD_COUNT - 1));
    assign stat.skip       = dec_skip;
    assign stat.last_word  = (ptr_reg == last_word_idx);
    assign stat.alloc_hit  = alloc_hit;
    assign stat.is_alloc   = alloc_reg;
    assign stat.out_free   = out_free;

`ifndef ASSERT_OFF
    a_ptr_in_span: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.chk |-> (ptr_reg <= last_word_idx))
        else $error("word pointer walked past the end of the span");

    a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result overwrote one not yet taken");

    a_load_shows_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("loaded result not presented");
`endif

endmodule

// File: rtl/frame_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// frame_bitmap_allocator: first-fit physical frame allocator
// One used bit per 4 KiB frame; allocate, free, and range mark requests.
//
//   channel | dir | handshake               | payload
//   --------+-----+-------------------------+--------------------------------
//   s_      | in  | s_tvalid / s_tready     | s_tuser action, s_tdata addr/end
//   m_      | out | m_tvalid / m_tready     | m_tuser status, m_tdata address
//   cfg_    | in  | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// each request passes decode, then a loop of one RAM read and one check /
// write-back per bitmap word, then the result handoff; ignored requests and
// allocates with nothing to scan go straight from decode to the handoff.
// after reset a clearing pass writes every bitmap word to all-used, one word
// a cycle (1024 words at the default capacity); s_tready stays low meanwhile.
// a finished result waits in the output register while m_tready is low; the
// next request is accepted, and its handoff waits for the register to empty.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator #(
    parameter int MAX_FRAMES = fba_pkg::MAX_FRAMES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // request stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [fba_pkg::IN_DATA_W-1:0]    s_tdata,   // [31:0] address, [64:32] range_end
    input  logic [fba_pkg::ACTION_W-1:0]     s_tuser,   // [1:0] action
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [fba_pkg::OUT_DATA_W-1:0]   m_tdata,   // [31:0] frame_address
    output logic [fba_pkg::STATUS_W-1:0]     m_tuser,   // [1:0] status
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fba_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [fba_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import fba_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // configuration is always taken
    assign cfg_ready = 1'b1;

    // sequencer
    fba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // bitmap, decode and result path
    fba_datapath #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .cfg_valid         (cfg_valid),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_action         (s_tuser),
        .in_address        (s_tdata[ADDR_W-1:0]),
        .in_range_end      (s_tdata[ADDR_W +: END_W]),
        .out_ready         (m_tready),
        .out_valid         (m_tvalid),
        .out_status        (m_tuser),
        .out_frame_address (m_tdata)
    );

endmodule
